FILE: design/indexed_min_heap_queue_unit_assert.svh
// Assertion macros for the heap queue checker.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define IMHQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define IMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/imhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;
   localparam int CAPACITY_DEF = 256;
   localparam int KEY_BITS_DEF = 32;
   localparam int HANDLES      = 256;
   localparam int HANDLE_BITS  = 8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_PRESENT = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RM_LAST,
      S_RM_START,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_PLACE,
      S_ROOT_RD,
      S_ROOT,
      S_OUT
   } fsm_type;
endpackage
`default_nettype wire

FILE: design/imhq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/indexed_min_heap_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Indexed min-heap queue: holds up to CAPACITY (key, handle) entries.
// Request channel: req_valid/req_stall with req_opcode, req_key, req_handle.
//   Opcode insert adds an entry, remove drops the entry of a handle from
//   anywhere in the heap, any other opcode only reports the root.
// Response channel: rsp_valid/rsp_stall; one response per request with the
//   status, the root entry, the entry count and an empty flag.
// One request is worked on at a time. Each heap level moved takes a
// registered read, then a compare and write back. The next request is taken
// once the response sits in the output register; while the receiver stalls,
// the response holds and a finished next request waits in its last state.
// Reset clears the fill count, the presence bits and the controller; slot
// and position memories need no clearing since only live entries are read.
module indexed_min_heap_queue_unit #(
   parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_key,
   input  wire logic [7:0]  req_handle,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_root_key,
   output logic [7:0]       rsp_root_handle,
   output logic [8:0]       rsp_entry_count,
   output logic             rsp_is_empty
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int HB = imhq_pkg::HANDLE_BITS;

   imhq_pkg::fsm_type state_ff, state_in;

   // request and working registers
   logic [1:0]          op_ff, op_in;
   logic [1:0]          status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       hole_ff, hole_in;
   logic [AW-1:0]       start_ff, start_in;
   logic [KEY_BITS-1:0] lkey_ff, lkey_in;
   logic [KEY_BITS-1:0] akey_ff, akey_in;
   logic [HB-1:0]       ahnd_ff, ahnd_in;
   logic                moved_ff, moved_in;
   logic [imhq_pkg::HANDLES-1:0] present_ff, present_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_key_ff, rsp_key_in;
   logic [7:0]          rsp_hnd_ff, rsp_hnd_in;
   logic [8:0]          rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_empty_ff, rsp_empty_in;

   // slot memory ports (key and handle share one address)
   logic                sk_we;
   logic [AW-1:0]       sk_wa, sk_ra;
   logic [KEY_BITS-1:0] sk_wd, sk_rd;
   logic [HB-1:0]       sh_wd, sh_rd;
   // second read port: a copy of slot memory for the right child
   logic [AW-1:0]       sr_ra;
   logic [KEY_BITS-1:0] sr_rk;
   logic [HB-1:0]       sr_rh;
   // handle position memory
   logic                hs_we;
   logic [HB-1:0]       hs_wa, hs_ra;
   logic [AW-1:0]       hs_wd, hs_rd;

   imhq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_a (
      .clock, .wr_en(sk_we), .wr_addr(sk_wa), .wr_data(sk_wd),
      .rd_addr(sk_ra), .rd_data(sk_rd));
   imhq_ram #(.WIDTH(HB), .DEPTH(CAPACITY)) u_hnd_a (
      .clock, .wr_en(sk_we), .wr_addr(sk_wa), .wr_data(sh_wd),
      .rd_addr(sk_ra), .rd_data(sh_rd));
   imhq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_b (
      .clock, .wr_en(sk_we), .wr_addr(sk_wa), .wr_data(sk_wd),
      .rd_addr(sr_ra), .rd_data(sr_rk));
   imhq_ram #(.WIDTH(HB), .DEPTH(CAPACITY)) u_hnd_b (
      .clock, .wr_en(sk_we), .wr_addr(sk_wa), .wr_data(sh_wd),
      .rd_addr(sr_ra), .rd_data(sr_rh));
   imhq_ram #(.WIDTH(AW), .DEPTH(imhq_pkg::HANDLES)) u_pos (
      .clock, .wr_en(hs_we), .wr_addr(hs_wa), .wr_data(hs_wd),
      .rd_addr(hs_ra), .rd_data(hs_rd));

   // heap index arithmetic, widened by one bit to catch overflow
   logic [AW:0] hole_w, lchild_w, rchild_w, cnt_w;
   logic [AW-1:0] parent;
   logic          left_ok, right_ok, pick_right;
   logic [KEY_BITS-1:0] ckey;
   logic [HB-1:0]       chnd;
   logic [AW-1:0]       cidx;

   always_comb begin
      hole_w   = {1'b0, hole_ff};
      lchild_w = {hole_ff, 1'b1};
      rchild_w = lchild_w + 1'b1;
      cnt_w    = (AW + 1)'(count_ff);
      parent   = AW'((hole_w - 1'b1) >> 1);
      left_ok  = lchild_w < cnt_w;
      right_ok = rchild_w < cnt_w;
      pick_right = right_ok && (sk_rd > sr_rk);
      ckey = pick_right ? sr_rk : sk_rd;
      chnd = pick_right ? sr_rh : sh_rd;
      cidx = pick_right ? AW'(rchild_w) : AW'(lchild_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imhq_pkg::S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      hole_ff       <= hole_in;
      start_ff      <= start_in;
      lkey_ff       <= lkey_in;
      akey_ff       <= akey_in;
      ahnd_ff       <= ahnd_in;
      moved_ff      <= moved_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_hnd_ff    <= rsp_hnd_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      hole_in    = hole_ff;
      start_in   = start_ff;
      lkey_in    = lkey_ff;
      akey_in    = akey_ff;
      ahnd_in    = ahnd_ff;
      moved_in   = moved_ff;
      present_in = present_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_empty_in  = rsp_empty_ff;
      req_stall = 1'b1;
      sk_we = 1'b0;
      sk_wa = hole_ff;
      sk_wd = akey_ff;
      sh_wd = ahnd_ff;
      sk_ra = hole_ff;
      sr_ra = AW'(rchild_w);
      hs_we = 1'b0;
      hs_wa = ahnd_ff;
      hs_wd = hole_ff;
      hs_ra = req_handle;

      unique case (state_ff)
         imhq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = req_opcode;
               akey_in   = KEY_BITS'(req_key);
               ahnd_in   = req_handle;
               status_in = imhq_pkg::ST_OK;
               moved_in  = 1'b0;
               state_in  = imhq_pkg::S_ROOT_RD;
               if (req_opcode == imhq_pkg::OP_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = imhq_pkg::ST_FULL;
                  end else if (present_ff[req_handle]) begin
                     status_in = imhq_pkg::ST_PRESENT;
                  end else begin
                     present_in[req_handle] = 1'b1;
                     hole_in  = AW'(count_ff);
                     count_in = count_ff + 1'b1;
                     state_in = imhq_pkg::S_UP_RD;
                  end
               end else if (req_opcode == imhq_pkg::OP_REMOVE) begin
                  if (!present_ff[req_handle] || count_ff == '0) begin
                     status_in = imhq_pkg::ST_ABSENT;
                  end else begin
                     present_in[req_handle] = 1'b0;
                     count_in = count_ff - 1'b1;
                     hole_in  = AW'(count_ff - 1'b1);
                     state_in = imhq_pkg::S_RM_LAST;
                  end
               end
            end
         end
         imhq_pkg::S_RM_LAST: begin
            // last slot read issued via hole; position read returned
            start_in = hs_rd;
            hole_in  = hs_rd;
            state_in = imhq_pkg::S_RM_START;
         end
         imhq_pkg::S_RM_START: begin
            akey_in = sk_rd;
            ahnd_in = sh_rd;
            lkey_in = sk_rd;
            if ({1'b0, start_ff} >= cnt_w) begin
               state_in = imhq_pkg::S_ROOT_RD;
            end else begin
               state_in = imhq_pkg::S_UP_RD;
            end
         end
         imhq_pkg::S_UP_RD: begin
            sk_ra = parent;
            if (hole_ff == '0) begin
               state_in = (op_ff == imhq_pkg::OP_REMOVE) ?
                          imhq_pkg::S_DN_RD : imhq_pkg::S_PLACE;
            end else begin
               state_in = imhq_pkg::S_UP_CMP;
            end
         end
         imhq_pkg::S_UP_CMP: begin
            if (akey_ff < sk_rd) begin
               sk_we = 1'b1;
               sk_wa = hole_ff;
               sk_wd = sk_rd;
               sh_wd = sh_rd;
               hs_we = 1'b1;
               hs_wa = sh_rd;
               hs_wd = hole_ff;
               hole_in  = parent;
               moved_in = 1'b1;
               state_in = imhq_pkg::S_UP_RD;
            end else if (op_ff == imhq_pkg::OP_REMOVE && !moved_ff) begin
               state_in = imhq_pkg::S_DN_RD;
            end else begin
               state_in = imhq_pkg::S_PLACE;
            end
         end
         imhq_pkg::S_DN_RD: begin
            sk_ra = AW'(lchild_w);
            sr_ra = AW'(rchild_w);
            state_in = (!moved_ff && left_ok) ? imhq_pkg::S_DN_CMP
                                               : imhq_pkg::S_PLACE;
         end
         imhq_pkg::S_DN_CMP: begin
            if (ckey < lkey_ff) begin
               sk_we = 1'b1;
               sk_wa = hole_ff;
               sk_wd = ckey;
               sh_wd = chnd;
               hs_we = 1'b1;
               hs_wa = chnd;
               hs_wd = hole_ff;
               hole_in  = cidx;
               state_in = imhq_pkg::S_DN_RD;
            end else begin
               state_in = imhq_pkg::S_PLACE;
            end
         end
         imhq_pkg::S_PLACE: begin
            sk_we = 1'b1;
            hs_we = 1'b1;
            state_in = imhq_pkg::S_ROOT_RD;
         end
         imhq_pkg::S_ROOT_RD: begin
            sk_ra = '0;
            state_in = imhq_pkg::S_ROOT;
         end
         imhq_pkg::S_ROOT: begin
            // keep the root on the read port for the output state
            sk_ra = '0;
            state_in = imhq_pkg::S_OUT;
         end
         imhq_pkg::S_OUT: begin
            // hold the finished request until the output register frees
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_cnt_in    = 9'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               rsp_key_in    = (count_ff == '0) ? 32'd0 : 32'(sk_rd);
               rsp_hnd_in    = (count_ff == '0) ? 8'd0 : sh_rd;
               state_in      = imhq_pkg::S_IDLE;
            end
            sk_ra = '0;
         end
         default: state_in = imhq_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_root_key    = rsp_key_ff;
   assign rsp_root_handle = rsp_hnd_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_is_empty    = rsp_empty_ff;
endmodule
`default_nettype wire

FILE: design/imhq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_queue_unit_assert.svh"
module imhq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_root_key,
   input wire logic [7:0]  rsp_root_handle,
   input wire logic [8:0]  rsp_entry_count,
   input wire logic        rsp_is_empty
);
   `IMHQ_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid && rsp_is_empty, rsp_root_key == 32'd0 && rsp_root_handle == 8'd0 && rsp_entry_count == 9'd0, "empty response has nonzero fields")
   `IMHQ_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= 9'd256 && (rsp_is_empty == (rsp_entry_count == 9'd0)), "entry count out of range")
   `IMHQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_root_key) && $stable(rsp_status), "stalled response changed")
   `IMHQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "second request taken during work")
endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_root_key, .rsp_root_handle, .rsp_entry_count,
   .rsp_is_empty
);
`default_nettype wire
